// File: design/llcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log line tokenizer package
// Shared types, codes and byte-class helpers for the column and word tokenizer.
// ----------------------------------------------------------------------------
package llcw_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WORD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_NUMBER = 2'd3;

    localparam logic [BYTE_W-1:0] RST_DELIMITER  = 8'd32;
    localparam logic [BYTE_W-1:0] RST_ESCAPE     = 8'd92;
    localparam logic [BYTE_W-1:0] RST_MAX_WORD   = 8'd255;
    localparam logic [BYTE_W-1:0] RST_MAX_NUMBER = 8'd3;
    localparam logic [BYTE_W-1:0] WORD_LEN_MAX   = 8'd255;

    localparam logic [1:0] CLS_DIGIT  = 2'd0;
    localparam logic [1:0] CLS_LETTER = 2'd1;
    localparam logic [1:0] CLS_OTHER  = 2'd2;

    localparam logic [2:0] OPEN_PAREN   = 3'd0;
    localparam logic [2:0] OPEN_SQUARE  = 3'd1;
    localparam logic [2:0] OPEN_CURLY   = 3'd2;
    localparam logic [2:0] OPEN_SINGLE  = 3'd3;
    localparam logic [2:0] OPEN_DOUBLE  = 3'd4;
    localparam logic [2:0] OPEN_NONE    = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              line_end;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              column_start;
        logic              word_start;
        logic              line_last;
    } t_out_item;

    typedef struct packed {
        logic [BYTE_W-1:0] delimiter_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] max_word_length;
        logic [BYTE_W-1:0] max_number_length;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        open_kind;
        logic              delimiter_seen;
        logic              skip_following;
        logic              line_begin;
        logic [BYTE_W-1:0] word_length;
        logic [1:0]        previous_class;
    } t_line_state;

    localparam t_line_state LINE_STATE_RESET = '{
        open_kind:      OPEN_NONE,
        delimiter_seen: 1'b0,
        skip_following: 1'b0,
        line_begin:     1'b1,
        word_length:    '0,
        previous_class: CLS_DIGIT
    };

    function automatic logic [1:0] class_of(input logic [BYTE_W-1:0] c);
        logic [1:0] cls;
        if (c >= "0" && c <= "9") begin
            cls = CLS_DIGIT;
        end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
            cls = CLS_LETTER;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

    function automatic logic [2:0] open_code(input logic [BYTE_W-1:0] c);
        logic [2:0] kind;
        case (c)
            "(":     kind = OPEN_PAREN;
            "[":     kind = OPEN_SQUARE;
            "{":     kind = OPEN_CURLY;
            "'":     kind = OPEN_SINGLE;
            "\"":    kind = OPEN_DOUBLE;
            default: kind = OPEN_NONE;
        endcase
        return kind;
    endfunction

    function automatic logic [BYTE_W-1:0] close_byte(input logic [2:0] kind);
        logic [BYTE_W-1:0] c;
        case (kind)
            OPEN_PAREN:  c = ")";
            OPEN_SQUARE: c = "]";
            OPEN_CURLY:  c = "}";
            OPEN_SINGLE: c = "'";
            default:     c = "\"";
        endcase
        return c;
    endfunction

endpackage

// File: design/llcw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log line tokenizer step logic
// Computes the flags for one byte and the line state that follows it.
// ----------------------------------------------------------------------------
module llcw_core
    import llcw_pkg::*;
(
    input  t_cfg        i_cfg,
    input  t_line_state i_state,
    input  t_in_item    i_item,
    output t_line_state o_next_state,
    output t_out_item   o_result
);

    logic [BYTE_W-1:0] c;
    logic [1:0]        cls;
    logic              is_delim;
    logic              col;
    logic              word;
    logic [2:0]        open_next;
    t_line_state       n_state;

    assign c        = i_item.data_byte;
    assign cls      = class_of(c);
    assign is_delim = (c == i_cfg.delimiter_byte);

    always_comb begin
        if (i_state.open_kind >= OPEN_NONE) begin
            open_next = open_code(c);
        end else if (c == close_byte(i_state.open_kind)) begin
            open_next = OPEN_NONE;
        end else begin
            open_next = i_state.open_kind;
        end
    end

    always_comb begin
        n_state            = i_state;
        col                = i_state.line_begin;
        n_state.line_begin = 1'b0;

        if (i_state.skip_following) begin
            n_state.skip_following = 1'b0;
        end else if (c == i_cfg.escape_byte) begin
            n_state.skip_following = 1'b1;
        end else begin
            if (i_state.delimiter_seen && !is_delim) begin
                col                    = 1'b1;
                n_state.delimiter_seen = 1'b0;
            end
            n_state.open_kind = open_next;
            if (open_next >= OPEN_NONE && is_delim) begin
                n_state.delimiter_seen = 1'b1;
            end
        end

        word = col
            || (cls != i_state.previous_class)
            || (cls == CLS_DIGIT && i_state.word_length >= i_cfg.max_number_length)
            || (i_state.word_length >= i_cfg.max_word_length);

        if (word) begin
            n_state.word_length = 8'd1;
        end else if (i_state.word_length < WORD_LEN_MAX) begin
            n_state.word_length = i_state.word_length + 8'd1;
        end
        n_state.previous_class = cls;

        if (i_item.line_end) begin
            n_state = LINE_STATE_RESET;
        end
    end

    assign o_next_state          = n_state;
    assign o_result.out_byte     = c;
    assign o_result.column_start = col;
    assign o_result.word_start   = word;
    assign o_result.line_last    = i_item.line_end;

endmodule

// File: design/log_line_column_word_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log line column and word tokenizer
// Passes log bytes through with column-start and word-start flags.
// ----------------------------------------------------------------------------
// The block takes one byte item per clock while o_stall is low; its result
// item is registered into a two-entry output stage. The line state is updated
// in the cycle the byte is accepted, so consecutive bytes need no gap. o_stall
// is a register and rises only when both entries are full, so a stalled output
// costs no throughput until the second entry fills.
module log_line_column_word_tokenizer
    import llcw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_item             i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_item            o_item
);

    t_cfg        r_cfg;
    t_line_state r_state;
    t_line_state n_state;
    t_out_item   result;
    t_out_item   r_out;
    t_out_item   n_out;
    t_out_item   r_skid;
    t_out_item   n_skid;
    logic        r_out_valid;
    logic        n_out_valid;
    logic        r_skid_valid;
    logic        n_skid_valid;
    logic        accept;
    logic        out_take;

    llcw_core u_core (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_item       (i_item),
        .o_next_state (n_state),
        .o_result     (result)
    );

    assign accept   = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_byte    <= RST_DELIMITER;
            r_cfg.escape_byte       <= RST_ESCAPE;
            r_cfg.max_word_length   <= RST_MAX_WORD;
            r_cfg.max_number_length <= RST_MAX_NUMBER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DELIMITER:  r_cfg.delimiter_byte    <= i_cfg_data;
                REG_ESCAPE:     r_cfg.escape_byte       <= i_cfg_data;
                REG_MAX_WORD:   r_cfg.max_word_length   <= i_cfg_data;
                REG_MAX_NUMBER: r_cfg.max_number_length <= i_cfg_data;
                default:        r_cfg                   <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LINE_STATE_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (out_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || out_take) begin
                n_out       = result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = result;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
